### design/cqs_pkg.sv
// Shared types and codes for the circular queue with search.
// Used by circular_queue_with_search_unit; depends on nothing.
package cqs_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int VALUE_W       = 32;
    localparam int FUNC_W        = 2;
    localparam int STATUS_W      = 3;
    localparam int CAP_W         = 5;
    localparam int CAP_RESET     = 16;

    typedef enum logic [FUNC_W-1:0] {
        FN_ENQ   = 2'd0,
        FN_DEQ   = 2'd1,
        FN_FIND  = 2'd2,
        FN_PRINT = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ENQ      = 3'd0,
        ST_OVF      = 3'd1,
        ST_DEQ      = 3'd2,
        ST_UNF      = 3'd3,
        ST_FOUND    = 3'd4,
        ST_NOTFOUND = 3'd5,
        ST_LISTED   = 3'd6,
        ST_EMPTY    = 3'd7
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_CHECK = 4'b0100,
        S_EMIT  = 4'b1000
    } state_t;

endpackage

### design/circular_queue_with_search_unit.sv
// Circular FIFO of 32-bit words with dequeue, search and listing.
// Depends on cqs_pkg.
//
// Channel  Dir  Handshake             Payload
// s_       in   s_tvalid / s_tready   s_tdata value, s_tuser func
// m_       out  m_tvalid / m_tready   m_tdata data, m_tuser status, m_tlast last
// cfg_     in   cfg_valid / cfg_ready cfg_data capacity
//
// Enqueue, overflow, underflow, empty and empty-queue find: S_IDLE, then S_EMIT.
// Dequeue: S_IDLE, S_READ, S_CHECK, S_EMIT. Find: S_IDLE, then S_READ and
// S_CHECK per stored word compared, then S_EMIT. Print: S_IDLE, then S_READ,
// S_CHECK, S_EMIT per listed word; S_READ waits on the single registered read port.
// Every output cycle lasts until m_tready; s_tready is low until the word is taken.
// aresetn (synchronous) empties the queue and sets capacity to 16 clamped to DEPTH.
module circular_queue_with_search_unit #(
    parameter int DEPTH = cqs_pkg::DEPTH_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [cqs_pkg::VALUE_W-1:0]  s_tdata,   // [31:0] value
    input  logic [cqs_pkg::FUNC_W-1:0]   s_tuser,   // [1:0] func
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [cqs_pkg::VALUE_W-1:0]  m_tdata,   // [31:0] data
    output logic [cqs_pkg::STATUS_W-1:0] m_tuser,   // [2:0] status
    output logic                         m_tlast,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [cqs_pkg::CAP_W-1:0]    cfg_data
);

    localparam int IW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW       = $clog2(DEPTH + 1);
    localparam int CAP_INIT = (cqs_pkg::CAP_RESET > DEPTH) ? DEPTH : cqs_pkg::CAP_RESET;

    cqs_pkg::state_t state_reg, state_next;

    logic [cqs_pkg::VALUE_W-1:0] mem [DEPTH];
    logic [cqs_pkg::VALUE_W-1:0] rd_data_reg;

    logic [CW-1:0] cap_reg, cap_next;
    logic [CW-1:0] occ_reg, occ_next;
    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    cqs_pkg::func_t func_reg, func_next;
    logic [cqs_pkg::VALUE_W-1:0] val_reg, val_next;

    cqs_pkg::status_t status_reg, status_next;
    logic [cqs_pkg::VALUE_W-1:0] data_reg, data_next;
    logic last_reg, last_next;

    logic          s_acc;
    logic          cfg_acc;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [CW:0]   tail_sum;
    logic [CW:0]   tail_wrap;
    logic [CW:0]   ptr_inc;
    logic [IW-1:0] ptr_adv;
    logic [CW:0]   head_inc;
    logic [IW-1:0] head_adv;
    logic          at_end;
    logic [CW-1:0] cap_clamp;

    assign cfg_ready = (state_reg == cqs_pkg::S_IDLE);
    assign s_tready  = (state_reg == cqs_pkg::S_IDLE) && !cfg_valid;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign s_acc     = s_tvalid && s_tready;

    assign m_tvalid = (state_reg == cqs_pkg::S_EMIT);
    assign m_tdata  = data_reg;
    assign m_tuser  = status_reg;
    assign m_tlast  = last_reg;

    always_comb begin
        if (cfg_data == '0) begin
            cap_clamp = CW'(1);
        end else if (32'(cfg_data) > 32'(DEPTH)) begin
            cap_clamp = CW'(DEPTH);
        end else begin
            cap_clamp = CW'(cfg_data);
        end
    end

    assign tail_sum  = (CW+1)'(head_reg) + (CW+1)'(occ_reg);
    assign tail_wrap = (tail_sum >= (CW+1)'(cap_reg)) ? tail_sum - (CW+1)'(cap_reg) : tail_sum;
    assign wr_addr   = IW'(tail_wrap);

    assign ptr_inc  = (CW+1)'(ptr_reg) + (CW+1)'(1);
    assign ptr_adv  = (ptr_inc == (CW+1)'(cap_reg)) ? '0 : IW'(ptr_inc);
    assign head_inc = (CW+1)'(head_reg) + (CW+1)'(1);
    assign head_adv = (head_inc == (CW+1)'(cap_reg)) ? '0 : IW'(head_inc);
    assign at_end   = ((CW+1)'(cnt_reg) + (CW+1)'(1)) == (CW+1)'(occ_reg);

    always_comb begin
        state_next  = state_reg;
        cap_next    = cap_reg;
        occ_next    = occ_reg;
        head_next   = head_reg;
        ptr_next    = ptr_reg;
        cnt_next    = cnt_reg;
        func_next   = func_reg;
        val_next    = val_reg;
        status_next = status_reg;
        data_next   = data_reg;
        last_next   = last_reg;
        wr_en       = 1'b0;
        unique case (state_reg)
            cqs_pkg::S_IDLE: begin
                if (cfg_acc) begin
                    cap_next  = cap_clamp;
                    occ_next  = '0;
                    head_next = '0;
                end else if (s_acc) begin
                    func_next = cqs_pkg::func_t'(s_tuser);
                    val_next  = s_tdata;
                    ptr_next  = head_reg;
                    cnt_next  = '0;
                    last_next = 1'b1;
                    unique case (cqs_pkg::func_t'(s_tuser))
                        cqs_pkg::FN_ENQ: begin
                            state_next = cqs_pkg::S_EMIT;
                            if (occ_reg >= cap_reg) begin
                                status_next = cqs_pkg::ST_OVF;
                                data_next   = '0;
                            end else begin
                                wr_en       = 1'b1;
                                occ_next    = occ_reg + CW'(1);
                                status_next = cqs_pkg::ST_ENQ;
                                data_next   = s_tdata;
                            end
                        end
                        cqs_pkg::FN_DEQ: begin
                            if (occ_reg == '0) begin
                                status_next = cqs_pkg::ST_UNF;
                                data_next   = '0;
                                state_next  = cqs_pkg::S_EMIT;
                            end else begin
                                state_next = cqs_pkg::S_READ;
                            end
                        end
                        cqs_pkg::FN_FIND: begin
                            if (occ_reg == '0) begin
                                status_next = cqs_pkg::ST_NOTFOUND;
                                data_next   = s_tdata;
                                state_next  = cqs_pkg::S_EMIT;
                            end else begin
                                state_next = cqs_pkg::S_READ;
                            end
                        end
                        cqs_pkg::FN_PRINT: begin
                            if (occ_reg == '0) begin
                                status_next = cqs_pkg::ST_EMPTY;
                                data_next   = '0;
                                state_next  = cqs_pkg::S_EMIT;
                            end else begin
                                state_next = cqs_pkg::S_READ;
                            end
                        end
                        default: state_next = cqs_pkg::S_IDLE;
                    endcase
                end
            end
            cqs_pkg::S_READ: begin
                state_next = cqs_pkg::S_CHECK;
            end
            cqs_pkg::S_CHECK: begin
                unique case (func_reg)
                    cqs_pkg::FN_DEQ: begin
                        status_next = cqs_pkg::ST_DEQ;
                        data_next   = rd_data_reg;
                        last_next   = 1'b1;
                        head_next   = head_adv;
                        occ_next    = occ_reg - CW'(1);
                        state_next  = cqs_pkg::S_EMIT;
                    end
                    cqs_pkg::FN_FIND: begin
                        data_next = val_reg;
                        last_next = 1'b1;
                        if (rd_data_reg == val_reg) begin
                            status_next = cqs_pkg::ST_FOUND;
                            state_next  = cqs_pkg::S_EMIT;
                        end else if (at_end) begin
                            status_next = cqs_pkg::ST_NOTFOUND;
                            state_next  = cqs_pkg::S_EMIT;
                        end else begin
                            cnt_next   = cnt_reg + CW'(1);
                            ptr_next   = ptr_adv;
                            state_next = cqs_pkg::S_READ;
                        end
                    end
                    default: begin
                        status_next = cqs_pkg::ST_LISTED;
                        data_next   = rd_data_reg;
                        last_next   = at_end;
                        state_next  = cqs_pkg::S_EMIT;
                    end
                endcase
            end
            cqs_pkg::S_EMIT: begin
                if (m_tready) begin
                    if (func_reg == cqs_pkg::FN_PRINT && !last_reg) begin
                        cnt_next   = cnt_reg + CW'(1);
                        ptr_next   = ptr_adv;
                        state_next = cqs_pkg::S_READ;
                    end else begin
                        state_next = cqs_pkg::S_IDLE;
                    end
                end
            end
            default: state_next = cqs_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= s_tdata;
        end
        rd_data_reg <= mem[ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cqs_pkg::S_IDLE;
            cap_reg   <= CW'(CAP_INIT);
            occ_reg   <= '0;
            head_reg  <= '0;
        end else begin
            state_reg <= state_next;
            cap_reg   <= cap_next;
            occ_reg   <= occ_next;
            head_reg  <= head_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg    <= ptr_next;
        cnt_reg    <= cnt_next;
        func_reg   <= func_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        data_reg   <= data_next;
        last_reg   <= last_next;
    end

    a_occ_le_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= cap_reg)
        else $error("occupancy above capacity");

    a_head_lt_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (CW+1)'(head_reg) < (CW+1)'(cap_reg))
        else $error("head index outside capacity");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("new word taken while busy");

    a_empty_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == cqs_pkg::ST_EMPTY) |-> m_tlast && (m_tdata == '0))
        else $error("empty result malformed");

    a_cfg_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready |=> occ_reg == '0)
        else $error("capacity write did not empty the queue");

endmodule
